// ===== rtl/mbc_pkg.sv =====
package mbc_pkg;

    localparam int MBC_MAX_SIDE   = 16;
    localparam int MBC_SIDE_W     = 5;
    localparam int MBC_SIDE_RESET = 10;
    localparam int MBC_RC_W       = 4;
    localparam int MBC_S_DATA_W   = 8;
    localparam int MBC_M_DATA_W   = 16;

    typedef enum logic [1:0] {
        DIR_TOP    = 2'd0,
        DIR_RIGHT  = 2'd1,
        DIR_BOTTOM = 2'd2,
        DIR_LEFT   = 2'd3
    } t_dir;

endpackage

// ===== rtl/maze_backtracker_carver.sv =====
// Channel   Dir  Word
// s_axis    in   tuser: op (restart); tdata: rand_dir
// m_axis    out  tdata: from_row, from_col, direction, carved, done_res
// i_cfg     in   write enable and side_used value
//
// A step passes S_MARK, S_UP and S_DN on its way to S_OUT, where the output
// word is loaded; every stack pop adds S_POP, S_UP, S_MID and S_DN, set by the
// single read port of the visited row memory (up, middle and down rows are
// read one after another). Restart and finished steps go from S_IDLE straight
// to S_OUT; s_axis_tready returns the cycle after the word is loaded.
// A side_used write starts a recount of the rows of the visited memory;
// s_axis_tready stays low meanwhile.
// Reset is synchronous; a full output register holds the result until taken.
module maze_backtracker_carver #(
    parameter int MAX_SIDE = mbc_pkg::MBC_MAX_SIDE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbc_pkg::MBC_SIDE_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] rand_dir, [7:2] zero
    input  logic [mbc_pkg::MBC_S_DATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] from_row, [7:4] from_col, [9:8] direction, [10] carved,
    // [11] done_res, [15:12] zero
    output logic [mbc_pkg::MBC_M_DATA_W-1:0]  m_axis_tdata
);
    import mbc_pkg::*;

    localparam int RW    = $clog2(MAX_SIDE);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int SA_W  = $clog2(CELLS);
    localparam int DEP_W = $clog2(CELLS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MARK, S_POP, S_UP, S_MID, S_DN, S_OUT
    } t_state;

    t_state                 r_state;
    logic [MBC_SIDE_W-1:0]  r_side;
    logic                   r_pop;
    t_dir                   r_dir;
    logic [RW-1:0]          r_row, r_col, r_cur_row, r_cur_col;
    logic [DEP_W-1:0]       r_depth, r_cnt;
    logic                   r_fin;
    logic [MAX_SIDE-1:0]    r_up, r_mid;
    logic [MAX_SIDE-1:0]    r_row_vld;
    logic                   r_vis_qv;
    logic [RW-1:0]          r_res_row, r_res_col;
    t_dir                   r_res_dir;
    logic                   r_res_carved;
    logic                   r_sweep;
    logic [RW:0]            r_sw_cnt;
    logic                   r_m_valid;
    logic [MBC_M_DATA_W-1:0] r_m_data;

    logic [MAX_SIDE-1:0]    mem_vis [MAX_SIDE];
    logic [MAX_SIDE-1:0]    r_vis_q;
    logic [2*RW-1:0]        mem_stk [CELLS];
    logic [2*RW-1:0]        r_stk_q;

    logic [MBC_SIDE_W-1:0]   side;
    logic [2*MBC_SIDE_W-1:0] sq_full;
    logic [DEP_W-1:0]        sq;
    logic [MAX_SIDE-1:0]     col_mask;
    logic [MAX_SIDE-1:0]     vis_q;
    logic [MAX_SIDE-1:0]     onehot;
    logic                    vis_rd_en, vis_wr_en, stk_rd_en, stk_wr_en;
    logic [RW-1:0]           vis_rd_addr;
    logic [SA_W-1:0]         stk_rd_addr;
    logic [RW-1:0]           stk_row, stk_col;
    logic [MBC_SIDE_W-1:0]   row_x, col_x;
    logic [3:0]              open;
    logic                    found, any_open, in_square, done_now, out_free;
    t_dir                    sel;
    logic [RW-1:0]           dst_row, dst_col;
    logic [DEP_W-1:0]        row_pop;

    assign side = (r_side < MBC_SIDE_W'(2)) ? MBC_SIDE_W'(2) :
                  (r_side > MBC_SIDE_W'(MAX_SIDE)) ? MBC_SIDE_W'(MAX_SIDE) : r_side;
    assign sq_full = side * side;
    assign sq      = DEP_W'(sq_full);

    always_comb begin
        for (int c = 0; c < MAX_SIDE; c++) begin
            col_mask[c] = (MBC_SIDE_W'(c) < side);
        end
    end

    assign vis_q     = r_vis_qv ? r_vis_q : '0;
    assign onehot    = MAX_SIDE'(1) << r_col;
    assign stk_row   = r_stk_q[2*RW-1:RW];
    assign stk_col   = r_stk_q[RW-1:0];
    assign row_x     = MBC_SIDE_W'(r_row);
    assign col_x     = MBC_SIDE_W'(r_col);
    assign in_square = (row_x < side) && (col_x < side);
    assign done_now  = r_fin || (r_cnt == sq);
    assign out_free  = !r_m_valid || m_axis_tready;
    assign row_pop   = DEP_W'($countones(vis_q & col_mask));

    // neighbor check: up and middle rows registered, down row on the read port
    always_comb begin
        open[DIR_TOP]    = (r_row != '0) && ((row_x - 1'b1) < side) && (col_x < side)
                           && !r_up[r_col];
        open[DIR_RIGHT]  = (row_x < side) && ((col_x + 1'b1) < side)
                           && !r_mid[RW'(r_col + 1'b1)];
        open[DIR_BOTTOM] = (col_x < side) && ((row_x + 1'b1) < side) && !vis_q[r_col];
        open[DIR_LEFT]   = (r_col != '0) && (row_x < side) && ((col_x - 1'b1) < side)
                           && !r_mid[RW'(r_col - 1'b1)];
        any_open = |open;
        found    = 1'b0;
        sel      = DIR_TOP;
        for (int k = 0; k < 4; k++) begin
            if (!found && open[2'(r_dir + 2'(k))]) begin
                found = 1'b1;
                sel   = t_dir'(2'(r_dir + 2'(k)));
            end
        end
        dst_row = r_row;
        dst_col = r_col;
        case (sel)
            DIR_TOP:    dst_row = r_row - 1'b1;
            DIR_RIGHT:  dst_col = r_col + 1'b1;
            DIR_BOTTOM: dst_row = r_row + 1'b1;
            DIR_LEFT:   dst_col = r_col - 1'b1;
            default:    dst_row = r_row;
        endcase
    end

    always_comb begin
        vis_rd_en   = 1'b0;
        vis_rd_addr = r_row;
        vis_wr_en   = 1'b0;
        stk_rd_en   = 1'b0;
        stk_rd_addr = SA_W'(r_depth - 1'b1);
        stk_wr_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (r_sweep && !i_cfg_we && (r_sw_cnt < (RW+1)'(MAX_SIDE))) begin
                    vis_rd_en   = 1'b1;
                    vis_rd_addr = RW'(r_sw_cnt);
                end else if (s_axis_tvalid && s_axis_tready) begin
                    vis_rd_en   = 1'b1;
                    vis_rd_addr = r_cur_row;
                end
            end
            S_MARK: begin
                vis_wr_en   = !vis_q[r_col];
                stk_wr_en   = (r_depth < DEP_W'(CELLS));
                vis_rd_en   = 1'b1;
                vis_rd_addr = (r_row == '0) ? r_row : r_row - 1'b1;
            end
            S_POP: begin
                vis_rd_en   = 1'b1;
                vis_rd_addr = (stk_row == '0) ? stk_row : stk_row - 1'b1;
            end
            S_UP: begin
                vis_rd_en = 1'b1;
                if (r_pop) begin
                    vis_rd_addr = r_row;
                end else begin
                    vis_rd_addr = (r_row == RW'(MAX_SIDE - 1)) ? r_row : r_row + 1'b1;
                end
            end
            S_MID: begin
                vis_rd_en   = 1'b1;
                vis_rd_addr = (r_row == RW'(MAX_SIDE - 1)) ? r_row : r_row + 1'b1;
            end
            S_DN: begin
                stk_rd_en = !(!r_pop && found) && !any_open && (r_depth != '0);
            end
            default: begin
                vis_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vis_wr_en) begin
            mem_vis[r_row] <= vis_q | onehot;
        end
        if (vis_rd_en) begin
            r_vis_q <= mem_vis[vis_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            mem_stk[r_depth[SA_W-1:0]] <= {r_row, r_col};
        end
        if (stk_rd_en) begin
            r_stk_q <= mem_stk[stk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_side    <= MBC_SIDE_W'(MBC_SIDE_RESET);
            r_pop     <= 1'b0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_depth   <= '0;
            r_cnt     <= '0;
            r_fin     <= 1'b0;
            r_row_vld <= '0;
            r_vis_qv  <= 1'b0;
            r_sweep   <= 1'b0;
            r_sw_cnt  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (vis_rd_en) begin
                r_vis_qv <= r_row_vld[vis_rd_addr];
            end
            if ((r_state == S_OUT) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_side   <= i_cfg_wdata;
                r_sweep  <= 1'b1;
                r_sw_cnt <= '0;
                r_cnt    <= '0;
            end else if (r_sweep) begin
                if ((r_sw_cnt != '0) && (MBC_SIDE_W'(r_sw_cnt - 1'b1) < side)) begin
                    r_cnt <= r_cnt + row_pop;
                end
                if (r_sw_cnt == (RW+1)'(MAX_SIDE)) begin
                    r_sweep <= 1'b0;
                end
                r_sw_cnt <= r_sw_cnt + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_dir        <= t_dir'(s_axis_tdata[1:0]);
                        r_row        <= r_cur_row;
                        r_col        <= r_cur_col;
                        r_pop        <= 1'b0;
                        r_res_row    <= '0;
                        r_res_col    <= '0;
                        r_res_dir    <= DIR_TOP;
                        r_res_carved <= 1'b0;
                        if (s_axis_tuser) begin
                            r_cnt     <= '0;
                            r_fin     <= 1'b0;
                            r_depth   <= '0;
                            r_cur_row <= '0;
                            r_cur_col <= '0;
                            r_row_vld <= '0;
                            r_state   <= S_OUT;
                        end else if (done_now) begin
                            r_fin   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MARK;
                        end
                    end
                end
                S_MARK: begin
                    r_mid <= vis_q | onehot;
                    if (!vis_q[r_col]) begin
                        r_row_vld[r_row] <= 1'b1;
                        if (in_square) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    if (r_depth < DEP_W'(CELLS)) begin
                        r_depth <= r_depth + 1'b1;
                    end
                    r_state <= S_UP;
                end
                S_POP: begin
                    r_row   <= stk_row;
                    r_col   <= stk_col;
                    r_state <= S_UP;
                end
                S_UP: begin
                    r_up    <= vis_q;
                    r_state <= r_pop ? S_MID : S_DN;
                end
                S_MID: begin
                    r_mid   <= vis_q;
                    r_state <= S_DN;
                end
                S_DN: begin
                    if (!r_pop && found) begin
                        r_res_row    <= r_row;
                        r_res_col    <= r_col;
                        r_res_dir    <= sel;
                        r_res_carved <= 1'b1;
                        r_cur_row    <= dst_row;
                        r_cur_col    <= dst_col;
                        r_state      <= S_OUT;
                    end else if (any_open || (r_depth == '0)) begin
                        r_cur_row <= r_row;
                        r_cur_col <= r_col;
                        r_state   <= S_OUT;
                    end else begin
                        r_depth <= r_depth - 1'b1;
                        r_pop   <= 1'b1;
                        r_state <= S_POP;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_data  <= {4'b0000, done_now, r_res_carved, r_res_dir,
                                      MBC_RC_W'(r_res_col), MBC_RC_W'(r_res_row)};
                        r_fin     <= done_now;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_sweep;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEP_W'(CELLS))
        else $error("stack depth beyond grid size");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sq)
        else $error("visited count beyond square size");

    a_carve_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[10] && m_axis_tdata[11]))
        else $error("carved word flagged done");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");
`endif

endmodule

// ===== sim/tb_maze_backtracker_carver.sv =====
module tb_maze_backtracker_carver;
    import mbc_pkg::*;

    localparam int GRID_CELLS = MBC_MAX_SIDE * MBC_MAX_SIDE;
    localparam int N_PHASES   = 12;
    localparam int HOLD_LEN   = 120;

    typedef struct packed {
        logic       op;
        logic [1:0] dir;
    } step_req_t;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        t_dir       dir;
        logic       carved;
        logic       done;
    } carve_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [MBC_SIDE_W-1:0]    i_cfg_wdata = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [MBC_S_DATA_W-1:0]  s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [MBC_M_DATA_W-1:0]  m_axis_tdata;

    // maze state as the block should hold it
    bit                       cell_seen [GRID_CELLS];
    logic [7:0]               trail [GRID_CELLS];
    int                       trail_depth;
    logic [7:0]               cur_cell;
    bit                       maze_done;
    logic [MBC_SIDE_W-1:0]    side_reg;

    step_req_t                pending_steps [$];
    carve_t                   expected_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int err_cnt;
    int n_accepted;
    int n_results;
    int n_carved;
    int n_done;

    int phase_side [N_PHASES] = '{3, 1, 5, 31, 6, 2, 17, 8, 0, 12, 7, 10};
    int phase_len  [N_PHASES] = '{90, 60, 100, 540, 14, 30, 30, 150, 50, 200, 120, 140};
    int phase_rr   [N_PHASES] = '{25, 12, 40, 0, 0, 0, 0, 60, 10, 100, 30, 50};
    bit phase_new  [N_PHASES] = '{1, 1, 1, 1, 1, 0, 0, 1, 1, 1, 0, 1};

    maze_backtracker_carver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic void clear_maze();
        foreach (cell_seen[i]) begin
            cell_seen[i] = 1'b0;
            trail[i] = '0;
        end
        trail_depth = 0;
        cur_cell = '0;
        maze_done = 1'b0;
    endfunction

    function automatic int side_span();
        if (side_reg < 2)
            return 2;
        if (side_reg > MBC_MAX_SIDE)
            return MBC_MAX_SIDE;
        return side_reg;
    endfunction

    function automatic bit open_toward(logic [7:0] spot, t_dir d, int s,
                                       output logic [7:0] dest);
        int r;
        int c;
        r = spot[7:4];
        c = spot[3:0];
        dest = '0;
        case (d)
            DIR_TOP: begin
                if (r == 0)
                    return 1'b0;
                r--;
            end
            DIR_RIGHT:  c++;
            DIR_BOTTOM: r++;
            default: begin
                if (c == 0)
                    return 1'b0;
                c--;
            end
        endcase
        if (r >= s || c >= s)
            return 1'b0;
        if (cell_seen[r * MBC_MAX_SIDE + c])
            return 1'b0;
        dest = 8'(r * MBC_MAX_SIDE + c);
        return 1'b1;
    endfunction

    function automatic bit has_exit(logic [7:0] spot, int s);
        logic [7:0] tmp;
        for (int k = 0; k < 4; k++)
            if (open_toward(spot, t_dir'(k), s, tmp))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit square_full(int s);
        for (int r = 0; r < s; r++)
            for (int c = 0; c < s; c++)
                if (!cell_seen[r * MBC_MAX_SIDE + c])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic carve_t carve_step(logic op, logic [1:0] start);
        carve_t     res;
        int         s;
        logic [7:0] spot;
        logic [7:0] dest;
        bit         found;
        t_dir       d;
        res = '0;
        if (op) begin
            clear_maze();
            return res;
        end
        s = side_span();
        if (maze_done || square_full(s)) begin
            maze_done = 1'b1;
            res.done = 1'b1;
            return res;
        end
        spot = cur_cell;
        cell_seen[spot] = 1'b1;
        found = 1'b0;
        d = DIR_TOP;
        for (int k = 0; k < 4; k++) begin
            if (!found) begin
                d = t_dir'(2'(start + k));
                found = open_toward(spot, d, s, dest);
            end
        end
        if (trail_depth < GRID_CELLS) begin
            trail[trail_depth] = spot;
            trail_depth++;
        end
        if (found) begin
            res.row = spot[7:4];
            res.col = spot[3:0];
            res.dir = d;
            res.carved = 1'b1;
            cur_cell = dest;
        end else begin
            while (!has_exit(spot, s) && trail_depth > 0) begin
                trail_depth--;
                spot = trail[trail_depth];
            end
            cur_cell = spot;
        end
        if (square_full(s))
            maze_done = 1'b1;
        res.done = maze_done;
        return res;
    endfunction

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // sender: hold a word until taken, then idle or offer the next
    always @(posedge i_clk) begin
        step_req_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(carve_step(s_axis_tuser, s_axis_tdata[1:0]));
                n_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_steps.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= nxt.op;
                    s_axis_tdata <= {6'b0, nxt.dir};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each word against the oldest prediction
    always @(posedge i_clk) begin
        carve_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    $error("unexpected word %h", m_axis_tdata);
                    err_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("from_row", want.row, m_axis_tdata[3:0]);
                    check_field("from_col", want.col, m_axis_tdata[7:4]);
                    check_field("direction", want.dir, m_axis_tdata[9:8]);
                    check_field("carved", want.carved, m_axis_tdata[10]);
                    check_field("done_res", want.done, m_axis_tdata[11]);
                    if (want.carved)
                        n_carved++;
                    if (want.done)
                        n_done++;
                end
            end
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_left <= HOLD_LEN;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic drain();
        do
            @(negedge i_clk);
        while (pending_steps.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    endtask

    task automatic write_side(int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= MBC_SIDE_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        side_reg = MBC_SIDE_W'(v);
    endtask

    task automatic queue_step(logic op, logic [1:0] dir);
        pending_steps.push_back(step_req_t'{op, dir});
    endtask

    initial begin
        bit restart;
        clear_maze();
        side_reg = MBC_SIDE_RESET;
        send_idle_pct = 37;
        recv_idle_pct = 82;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default side: each start direction, restart, step
        @(negedge i_clk);
        for (int k = 0; k < 4; k++)
            queue_step(1'b0, 2'(k));
        queue_step(1'b1, 2'd3);
        queue_step(1'b0, 2'd2);
        drain();

        // side below range: 2x2 grid runs out, idle steps after it
        write_side(0);
        @(negedge i_clk);
        queue_step(1'b1, 2'd0);
        for (int k = 0; k < 4; k++)
            queue_step(1'b0, 2'(k));
        queue_step(1'b0, 2'd3);
        queue_step(1'b0, 2'd1);
        queue_step(1'b0, 2'd2);
        queue_step(1'b1, 2'd2);
        queue_step(1'b0, 2'd1);
        queue_step(1'b0, 2'd0);
        queue_step(1'b0, 2'd3);

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p == 4) begin
                send_idle_pct = 82;
                recv_idle_pct = 37;
            end else if (p == 9) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_side(phase_side[p]);
            @(negedge i_clk);
            if (p == 9)
                hold_seq++;
            if (phase_new[p])
                queue_step(1'b1, 2'($urandom_range(3)));
            for (int i = 0; i < phase_len[p]; i++) begin
                restart = phase_rr[p] != 0 && $urandom_range(phase_rr[p] - 1) == 0;
                queue_step(restart, 2'($urandom_range(3)));
            end
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("carver run: %0d words in, %0d out, %0d walls carved, %0d done answers",
                 n_accepted, n_results, n_carved, n_done);
        $display("sides 2..16 incl. clamped values, mid-run resize, long output stall");
        if (err_cnt == 0)
            $display("tb_maze_backtracker_carver: done, clean");
        else
            $display("tb_maze_backtracker_carver: done, errors");
        $finish;
    end

    initial begin
        #40000000;
        $display("tb_maze_backtracker_carver: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mbc_pkg.sv
rtl/maze_backtracker_carver.sv
sim/tb_maze_backtracker_carver.sv
